// ----- rtl/core/page_framebuffer_pixel_engine_assert.svh -----
// Assertion macros for the page framebuffer pixel engine.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef PAGE_FRAMEBUFFER_PIXEL_ENGINE_ASSERT_SVH
`define PAGE_FRAMEBUFFER_PIXEL_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PFE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel engine same-cycle check failed");

// Next-cycle implication, checked outside reset
`define PFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel engine next-cycle check failed");

`endif

// ----- rtl/core/pfe_pkg.sv -----
// Shared constants and types for the page framebuffer pixel engine.
// No dependencies; used by the store, the controller and the top level.
package pfe_pkg;

  // Screen geometry
  localparam int SCREEN_COLUMNS = 128;
  localparam int SCREEN_PAGES   = 8;
  localparam int SCREEN_ROWS    = SCREEN_PAGES * 8;
  localparam int STORE_DEPTH    = SCREEN_PAGES * SCREEN_COLUMNS;

  localparam int COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int PAGE_W = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
  localparam int PR_W   = PAGE_W + 3;  // page plus row within page
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  // Action codes carried in the input tuser
  typedef enum logic [2:0] {
    ACT_SET_PIXEL  = 3'd0,
    ACT_CLEAR_AREA = 3'd1,
    ACT_INV_AREA   = 3'd2,
    ACT_GET_PIXEL  = 3'd3,
    ACT_BLIT_BYTE  = 3'd4,
    ACT_READ_BYTE  = 3'd5,
    ACT_CLEAR_ALL  = 3'd6
  } act_t;

  // Word update applied during a walk
  typedef enum logic [2:0] {
    MOD_OR,
    MOD_CLR,
    MOD_XOR,
    MOD_PIXEL,
    MOD_BYTE
  } mod_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_DONE
  } st_t;

  // One result word
  typedef struct packed {
    logic       pixel_value;
    logic [7:0] column_byte;
    logic       on_screen;
  } res_t;

  // Result offer from the controller to the output register
  typedef struct packed {
    logic valid;
    res_t res;
  } ctrl_res_t;

endpackage

// ----- rtl/core/page_framebuffer_pixel_engine.sv -----
// Page framebuffer pixel engine, top level.
// Channels: in_* carries one action word (tuser = action code, tdata = coordinates,
// area size and image byte); out_* returns exactly one result word per action.
// Each action is decoded, then the controller walks the column bytes it touches
// through one store word per read-modify-write pair: a read cycle, then a modify
// and write-back cycle on the same address, so accesses never overlap.
// Per action: an unused action or fully off-screen target goes straight to done;
//   set/get pixel and read byte read (and for set, write back) a single word;
//   blit byte touches one word in each of the pages touched, 1 or 2;
//   clear/invert area touches each clipped column of each page spanned;
//   clear all sweeps zeros through all SCREEN_PAGES * SCREEN_COLUMNS words.
// The store has one write port and one registered read port.
// Reset: the controller sweeps zeros through all 1024 store words, one per cycle,
// holding in_tready low; then the screen reads as cleared.
// Stall: a result waits in the output register while the next word is accepted;
// a second result waits in the controller until the register frees.
// Depends on pfe_pkg, pfe_ctrl and the assertion macro header.
module page_framebuffer_pixel_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // pos_x[15:0], pos_y[31:16], area_width[39:32],
                                  // area_height[47:40], image_byte[55:48]
  input  logic [2:0]  in_tuser,   // action[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // pixel_value[0], column_byte[8:1], on_screen[9],
                                  // zero[15:10]
);
  import pfe_pkg::*;

  ctrl_res_t ctl_res;
  logic      res_ready;
  logic      out_valid_r, out_valid_nxt;
  res_t      out_res_r, out_res_nxt;

  // Output register frees when empty or being taken
  assign res_ready = !out_valid_r || out_tready;

  // Load or drain the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (ctl_res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = ctl_res.res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.on_screen, out_res_r.column_byte,
                       out_res_r.pixel_value};

  pfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .ctl_res   (ctl_res),
    .res_ready (res_ready)
  );

  // Checks
`include "page_framebuffer_pixel_engine_assert.svh"

  `PFE_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `PFE_ASSERT_IMPL(a_no_accept_with_pending, in_tready, !ctl_res.valid)
  `PFE_ASSERT_NEXT(a_pending_held, ctl_res.valid && !res_ready,
                   ctl_res.valid && $stable(ctl_res.res))
  `PFE_ASSERT_NEXT(a_result_loaded, ctl_res.valid && res_ready,
                   out_tvalid && (out_tdata[9] == $past(ctl_res.res.on_screen)))

endmodule

// ----- rtl/core/pfe_store.sv -----
// Display store: one write port and one registered read port.
// Depends on pfe_pkg for depth and address width.
module pfe_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [pfe_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                wdata,
  input  logic [pfe_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                rdata
);
  import pfe_pkg::*;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/pfe_ctrl.sv -----
// Controller: decodes an action, walks the affected column bytes with
// read-modify-write cycles on the store, and sweeps the store clear.
// Depends on pfe_pkg and instantiates pfe_store.
module pfe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [55:0]        in_tdata,
  input  logic [2:0]         in_tuser,
  output pfe_pkg::ctrl_res_t ctl_res,
  input  logic               res_ready
);
  import pfe_pkg::*;

  localparam logic signed [15:0] COLS_S16    = 16'(SCREEN_COLUMNS);
  localparam logic signed [15:0] ROWS_S16    = 16'(SCREEN_ROWS);
  localparam logic signed [15:0] PAGES_S16   = 16'(SCREEN_PAGES);
  localparam logic signed [16:0] PAGES_S17   = 17'(SCREEN_PAGES);
  localparam logic signed [15:0] BLIT_TOP_S16 = -16'sd8;
  localparam logic signed [17:0] COL_MAX_S18 = 18'(SCREEN_COLUMNS - 1);
  localparam logic signed [17:0] ROW_MAX_S18 = 18'(SCREEN_ROWS - 1);
  localparam logic [ADDR_W-1:0]  LAST_ADDR   = ADDR_W'(STORE_DEPTH - 1);

  function automatic logic [ADDR_W-1:0] word_addr(input logic [PAGE_W-1:0] p,
                                                  input logic [COL_W-1:0]  c);
    return ADDR_W'(ADDR_W'(p) * ADDR_W'(SCREEN_COLUMNS)) + ADDR_W'(c);
  endfunction

  // Registers
  st_t               st_r, st_nxt;
  logic              resp_pend_r, resp_pend_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  mod_t              mod_r, mod_nxt;
  logic [PAGE_W-1:0] page_cur_r, page_cur_nxt;
  logic [PAGE_W-1:0] page_first_r, page_first_nxt;
  logic [PAGE_W-1:0] page_end_r, page_end_nxt;
  logic [COL_W-1:0]  col_cur_r, col_cur_nxt;
  logic [COL_W-1:0]  col_lo_r, col_lo_nxt;
  logic [COL_W-1:0]  col_hi_r, col_hi_nxt;
  logic [PR_W-1:0]   ylo_r, ylo_nxt;
  logic [PR_W-1:0]   yhi_r, yhi_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [7:0]        data_a_r, data_a_nxt;
  logic [7:0]        data_b_r, data_b_nxt;
  res_t              res_r, res_nxt;

  // Decode results
  logic              accept;
  logic              dec_walk, dec_clear;
  mod_t              dec_mod;
  logic [PAGE_W-1:0] dec_page_first, dec_page_end;
  logic [COL_W-1:0]  dec_col_lo, dec_col_hi;
  logic [PR_W-1:0]   dec_ylo, dec_yhi;
  logic [7:0]        dec_data_a, dec_data_b;
  res_t              dec_res;

  // Decode locals
  act_t               act;
  logic signed [15:0] x_s, y_s, pg16;
  logic signed [16:0] pg1;
  logic signed [17:0] xs18, ys18, xe18, ye18, xlo18, xhi18, ylo18, yhi18;
  logic [7:0]         w_u, h_u, img;
  logic [2:0]         sft;
  logic [7:0]         blit_lo, blit_hi;
  logic               x_ok, pt_ok, lo_in, hi_in, area_any;
  logic [PR_W-1:0]    y_pr, ylo_pr, yhi_pr;

  // Walk datapath
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic [7:0]        row_mask, or_data;
  logic              last_col, last_page;
  logic [PR_W-1:0]   row_abs;

  assign in_tready = (st_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Decode the incoming word
  always_comb begin
    act  = act_t'(in_tuser);
    x_s  = $signed(in_tdata[15:0]);
    y_s  = $signed(in_tdata[31:16]);
    w_u  = in_tdata[39:32];
    h_u  = in_tdata[47:40];
    img  = in_tdata[55:48];
    sft  = in_tdata[18:16];
    pg16 = y_s >>> 3;
    pg1  = {pg16[15], pg16} + 17'sd1;

    x_ok  = (x_s >= 16'sd0) && (x_s < COLS_S16);
    pt_ok = x_ok && (y_s >= 16'sd0) && (y_s < ROWS_S16);
    lo_in = (pg16 >= 16'sd0) && (pg16 < PAGES_S16);
    hi_in = (pg1 >= 17'sd0) && (pg1 < PAGES_S17);

    blit_lo = 8'(img << sft);
    blit_hi = (sft == 3'd0) ? 8'd0 : 8'(img >> (4'd8 - {1'b0, sft}));

    xs18  = {{2{x_s[15]}}, x_s};
    ys18  = {{2{y_s[15]}}, y_s};
    xe18  = xs18 + $signed({10'd0, w_u}) - 18'sd1;
    ye18  = ys18 + $signed({10'd0, h_u}) - 18'sd1;
    xlo18 = (xs18 < 18'sd0) ? 18'sd0 : xs18;
    ylo18 = (ys18 < 18'sd0) ? 18'sd0 : ys18;
    xhi18 = (xe18 > COL_MAX_S18) ? COL_MAX_S18 : xe18;
    yhi18 = (ye18 > ROW_MAX_S18) ? ROW_MAX_S18 : ye18;
    area_any = (xlo18 <= xhi18) && (ylo18 <= yhi18);

    y_pr   = PR_W'(y_s);
    ylo_pr = PR_W'(ylo18);
    yhi_pr = PR_W'(yhi18);

    dec_walk       = 1'b0;
    dec_clear      = 1'b0;
    dec_mod        = MOD_BYTE;
    dec_page_first = y_pr[PR_W-1:3];
    dec_page_end   = y_pr[PR_W-1:3];
    dec_col_lo     = COL_W'(x_s);
    dec_col_hi     = COL_W'(x_s);
    dec_ylo        = '0;
    dec_yhi        = '0;
    dec_data_a     = 8'(8'd1 << sft);
    dec_data_b     = 8'd0;
    dec_res        = '0;

    case (act)
      ACT_SET_PIXEL: begin
        if (pt_ok) begin
          dec_walk           = 1'b1;
          dec_mod            = MOD_OR;
          dec_res.on_screen  = 1'b1;
        end
      end
      ACT_GET_PIXEL: begin
        if (pt_ok) begin
          dec_walk           = 1'b1;
          dec_mod            = MOD_PIXEL;
          dec_res.on_screen  = 1'b1;
        end
      end
      ACT_READ_BYTE: begin
        dec_page_first = PAGE_W'(pg16);
        dec_page_end   = PAGE_W'(pg16);
        if (x_ok && lo_in) begin
          dec_walk          = 1'b1;
          dec_mod           = MOD_BYTE;
          dec_res.on_screen = 1'b1;
        end
      end
      ACT_BLIT_BYTE: begin
        dec_page_first    = lo_in ? PAGE_W'(pg16) : PAGE_W'(pg1);
        dec_page_end      = hi_in ? PAGE_W'(pg1) : PAGE_W'(pg16);
        dec_data_a        = lo_in ? blit_lo : blit_hi;
        dec_data_b        = blit_hi;
        dec_mod           = MOD_OR;
        dec_walk          = x_ok && (lo_in || hi_in);
        dec_res.on_screen = x_ok && (y_s > BLIT_TOP_S16) && (y_s < ROWS_S16);
      end
      ACT_CLEAR_AREA, ACT_INV_AREA: begin
        dec_mod           = (act == ACT_INV_AREA) ? MOD_XOR : MOD_CLR;
        dec_page_first    = ylo_pr[PR_W-1:3];
        dec_page_end      = yhi_pr[PR_W-1:3];
        dec_col_lo        = COL_W'(xlo18);
        dec_col_hi        = COL_W'(xhi18);
        dec_ylo           = ylo_pr;
        dec_yhi           = yhi_pr;
        dec_walk          = area_any;
        dec_res.on_screen = area_any;
      end
      ACT_CLEAR_ALL: begin
        dec_clear         = 1'b1;
        dec_res.on_screen = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Row mask of the current page within the area rows
  always_comb begin
    row_mask = '0;
    row_abs  = '0;
    for (int b = 0; b < 8; b++) begin
      row_abs     = {page_cur_r, 3'(b)};
      row_mask[b] = (row_abs >= ylo_r) && (row_abs <= yhi_r);
    end
  end

  assign or_data   = (page_cur_r == page_first_r) ? data_a_r : data_b_r;
  assign last_col  = (col_cur_r == col_hi_r);
  assign last_page = (page_cur_r == page_end_r);

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLR: begin
        if (clr_cnt_r == LAST_ADDR) begin
          st_nxt = resp_pend_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (dec_clear) begin
            st_nxt = ST_CLR;
          end else if (dec_walk) begin
            st_nxt = ST_RD;
          end else begin
            st_nxt = ST_DONE;
          end
        end
      end
      ST_RD: begin
        st_nxt = ST_WR;
      end
      ST_WR: begin
        st_nxt = (last_col && last_page) ? ST_DONE : ST_RD;
      end
      ST_DONE: begin
        if (res_ready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath
  always_comb begin
    resp_pend_nxt  = resp_pend_r;
    clr_cnt_nxt    = clr_cnt_r;
    mod_nxt        = mod_r;
    page_cur_nxt   = page_cur_r;
    page_first_nxt = page_first_r;
    page_end_nxt   = page_end_r;
    col_cur_nxt    = col_cur_r;
    col_lo_nxt     = col_lo_r;
    col_hi_nxt     = col_hi_r;
    ylo_nxt        = ylo_r;
    yhi_nxt        = yhi_r;
    bit_nxt        = bit_r;
    data_a_nxt     = data_a_r;
    data_b_nxt     = data_b_r;
    res_nxt        = res_r;

    mem_raddr = word_addr(page_cur_r, col_cur_r);
    mem_waddr = word_addr(page_cur_r, col_cur_r);
    mem_we    = 1'b0;
    mem_wdata = mem_rdata;

    ctl_res.valid = 1'b0;
    ctl_res.res   = res_r;

    case (st_r)
      ST_CLR: begin
        // Sweep zeros through the store
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = 8'd0;
        clr_cnt_nxt = (clr_cnt_r == LAST_ADDR) ? '0 : clr_cnt_r + 1'b1;
      end
      ST_IDLE: begin
        // Latch the decoded action
        if (accept) begin
          resp_pend_nxt  = 1'b1;
          mod_nxt        = dec_mod;
          page_cur_nxt   = dec_page_first;
          page_first_nxt = dec_page_first;
          page_end_nxt   = dec_page_end;
          col_cur_nxt    = dec_col_lo;
          col_lo_nxt     = dec_col_lo;
          col_hi_nxt     = dec_col_hi;
          ylo_nxt        = dec_ylo;
          yhi_nxt        = dec_yhi;
          bit_nxt        = sft;
          data_a_nxt     = dec_data_a;
          data_b_nxt     = dec_data_b;
          res_nxt        = dec_res;
        end
      end
      ST_WR: begin
        // Modify the word read last cycle and write it back, or capture it for a get or read
        case (mod_r)
          MOD_OR: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | or_data;
          end
          MOD_CLR: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata & ~row_mask;
          end
          MOD_XOR: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata ^ row_mask;
          end
          MOD_PIXEL: begin
            res_nxt.pixel_value = mem_rdata[bit_r];
          end
          MOD_BYTE: begin
            res_nxt.column_byte = mem_rdata;
          end
          default: begin
          end
        endcase
        // Advance column, then page
        if (last_col) begin
          col_cur_nxt = col_lo_r;
          if (!last_page) begin
            page_cur_nxt = page_cur_r + 1'b1;
          end
        end else begin
          col_cur_nxt = col_cur_r + 1'b1;
        end
      end
      ST_DONE: begin
        // Offer the result until the output register takes it
        ctl_res.valid = 1'b1;
        if (res_ready) begin
          resp_pend_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLR;
      resp_pend_r <= 1'b0;
      clr_cnt_r   <= '0;
    end else begin
      st_r        <= st_nxt;
      resp_pend_r <= resp_pend_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mod_r        <= mod_nxt;
    page_cur_r   <= page_cur_nxt;
    page_first_r <= page_first_nxt;
    page_end_r   <= page_end_nxt;
    col_cur_r    <= col_cur_nxt;
    col_lo_r     <= col_lo_nxt;
    col_hi_r     <= col_hi_nxt;
    ylo_r        <= ylo_nxt;
    yhi_r        <= yhi_nxt;
    bit_r        <= bit_nxt;
    data_a_r     <= data_a_nxt;
    data_b_r     <= data_b_nxt;
    res_r        <= res_nxt;
  end

  pfe_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
